// ===== design/rvx_pkg.sv =====
// Package for the RV32IM/Zicsr execute core: shared types, codes and constants.
// No dependencies; every other design file imports it.
package rvx_pkg;

  localparam int CSR_COUNT_DEF = 4096;

  // action codes of an input request
  localparam logic [1:0] ACT_EXEC  = 2'd0;
  localparam logic [1:0] ACT_LDRET = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ILLEGAL = 3'd1;
  localparam logic [2:0] ST_MISALGN = 3'd2;
  localparam logic [2:0] ST_BREAK   = 3'd3;
  localparam logic [2:0] ST_ECALL   = 3'd4;
  localparam logic [2:0] ST_HALTED  = 3'd5;

  // memory request codes
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  // major opcodes, bits [6:2]
  localparam logic [4:0] OPC_LOAD   = 5'h00;
  localparam logic [4:0] OPC_MISC   = 5'h03;
  localparam logic [4:0] OPC_OPIMM  = 5'h04;
  localparam logic [4:0] OPC_AUIPC  = 5'h05;
  localparam logic [4:0] OPC_STORE  = 5'h08;
  localparam logic [4:0] OPC_OP     = 5'h0C;
  localparam logic [4:0] OPC_LUI    = 5'h0D;
  localparam logic [4:0] OPC_BRANCH = 5'h18;
  localparam logic [4:0] OPC_JALR   = 5'h19;
  localparam logic [4:0] OPC_JAL    = 5'h1B;
  localparam logic [4:0] OPC_SYSTEM = 5'h1C;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;

  // request as queued between front and back, with its class
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] instr_word;
    logic [31:0] load_data;
    logic        is_md;
    logic        is_div;
  } item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        rd_write;
    logic [4:0]  rd_index;
    logic [31:0] rd_value;
    logic [1:0]  mem_request;
    logic [1:0]  mem_size;
    logic [31:0] mem_address;
    logic [31:0] mem_write_data;
    logic [2:0]  status;
    logic [30:0] exit_code;
  } res_t;

endpackage

// ===== design/rvx_front.sv =====
// Front end: accepts input requests, classifies multiply/divide work and
// queues them for the back end in a two-entry queue. Depends on rvx_pkg.
module rvx_front import rvx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_instr_word,
  input  logic [31:0] in_load_data,
  input  logic        hold,
  input  logic        q_pop,
  output logic        q_empty,
  output item_t       q_head
);

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  item_t      itm;

  assign in_full = (cnt_r == 2'd2) || hold;
  assign push    = in_push && !in_full;
  assign q_empty = (cnt_r == 2'd0);
  assign q_head  = mem_r[rp_r];

  always_comb begin
    itm.action     = in_action;
    itm.instr_word = in_instr_word;
    itm.load_data  = in_load_data;
    itm.is_md      = (in_action == ACT_EXEC) && (in_instr_word[1:0] == 2'b11) &&
                     (in_instr_word[6:2] == OPC_OP) && (in_instr_word[31:25] == F7_MULDIV);
    itm.is_div     = itm.is_md && in_instr_word[14];
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= itm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== design/rvx_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Unsigned magnitudes only; sign and special cases are handled by the caller.
module rvx_div import rvx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);

  logic [31:0] rem_r, quo_r, dvs_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] sh, diff;

  assign sh   = {rem_r, quo_r[31]};
  assign diff = sh - {1'b0, dvs_r};
  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_r <= diff[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= sh[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/rvx_back.sv =====
// Back end: register file, CSR memory, pc and run state; executes one queued
// request at a time through a small sequencer. Depends on rvx_pkg, rvx_div.
module rvx_back import rvx_pkg::*; #(
  parameter int CSR_COUNT = CSR_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  item_t       q_head,
  output logic        q_pop,
  input  logic        out_full,
  output logic        out_push,
  output res_t        out_res,
  input  logic [31:0] entry_address,
  input  logic [31:0] stack_top,
  output logic        clearing
);

  localparam int CSR_AW = (CSR_COUNT > 1) ? $clog2(CSR_COUNT) : 1;
  localparam logic [12:0] CSR_LIM = 13'(CSR_COUNT);
  localparam logic [CSR_AW-1:0] CSR_LAST = CSR_AW'(CSR_COUNT - 1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [CSR_AW-1:0] clr_cnt_r;

  // architectural state
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_r;
  logic [31:0] csr_mem [CSR_COUNT];
  logic [31:0] pc_r;
  logic        run_r, lp_r;
  logic [4:0]  ldst_r;
  logic [2:0]  lk_r;

  // current request and its operands
  item_t       it_r;
  logic [31:0] ra_q, rb_q, csr_q;
  logic        va_q, vb_q;
  logic [31:0] prod_lo_r, prod_hi_r;
  res_t        res_r;

  logic [31:0] w, a, b, immi, imm_s, imm_b, imm_j, npc, tgt, md_val, csr_old, src;
  logic [31:0] da, db, alu, ldx;
  logic [4:0]  rd, r1, r2, rb_addr;
  logic [2:0]  f3, st;
  logic [6:0]  f7;
  logic [11:0] csr;
  logic        csr_ok, take, rd_want, latch;
  logic [4:0]  rd_idx;
  logic [31:0] rd_val;
  logic [31:0] pc_nxt;
  logic        run_nxt, lp_nxt;
  logic [4:0]  ldst_nxt;
  logic [2:0]  lk_nxt;
  logic        csr_we;
  logic [31:0] csr_wd;
  logic        div_done, div_start;
  logic [31:0] div_q, div_r;
  logic        ovf;
  logic signed [65:0] prod;
  res_t        r;

  assign w  = it_r.instr_word;
  assign rd = w[11:7];
  assign f3 = w[14:12];
  assign r1 = w[19:15];
  assign r2 = w[24:20];
  assign f7 = w[31:25];
  assign csr = w[31:20];
  assign a  = va_q ? ra_q : '0;
  assign b  = vb_q ? rb_q : '0;
  assign csr_ok  = {1'b0, csr} < CSR_LIM;
  assign csr_old = csr_ok ? csr_q : '0;

  assign immi  = {{20{w[31]}}, w[31:20]};
  assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
  assign imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};

  assign clearing = (state_r == S_CLR);
  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign out_push = (state_r == S_WB) && !out_full;
  assign out_res  = res_r;

  // ECALL looks at x3 through the second read port
  assign rb_addr = (q_head.instr_word[6:2] == OPC_SYSTEM) ? 5'd3 : q_head.instr_word[24:20];

  // register file and CSR memory: reads on pop, writes when a result is latched
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ra_q <= rf_mem[q_head.instr_word[19:15]];
      rb_q <= rf_mem[rb_addr];
      va_q <= rf_vld_r[q_head.instr_word[19:15]];
      vb_q <= rf_vld_r[rb_addr];
      it_r <= q_head;
    end
    if (latch && r.rd_write) rf_mem[r.rd_index] <= r.rd_value;
  end

  always_ff @(posedge clk) begin
    if (clearing) csr_mem[clr_cnt_r] <= '0;
    else if (latch && csr_we && csr_ok) csr_mem[csr[CSR_AW-1:0]] <= csr_wd;
    if (q_pop) csr_q <= csr_mem[q_head.instr_word[20+CSR_AW-1:20]];
  end

  // multiply: 33x33 signed covers all four variants
  assign prod = $signed({(f3 != 3'd3) & a[31], a}) * $signed({(f3 == 3'd1) & b[31], b});

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      prod_lo_r <= prod[31:0];
      prod_hi_r <= prod[63:32];
    end
  end

  assign ovf       = (a == 32'h8000_0000) && (b == 32'hffff_ffff);
  assign da        = (!f3[0] && a[31]) ? (32'd0 - a) : a;
  assign db        = (!f3[0] && b[31]) ? (32'd0 - b) : b;
  assign div_start = (state_r == S_READ) && it_r.is_div;

  rvx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (da),
    .divisor  (db),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_r)
  );

  always_comb begin
    unique case (f3)
      3'd0:    md_val = prod_lo_r;
      3'd1,
      3'd2,
      3'd3:    md_val = prod_hi_r;
      3'd4:    md_val = (b == '0) ? 32'hffff_ffff : ovf ? a :
                        (a[31] ^ b[31]) ? (32'd0 - div_q) : div_q;
      3'd5:    md_val = (b == '0) ? 32'hffff_ffff : div_q;
      3'd6:    md_val = (b == '0) ? a : ovf ? '0 : a[31] ? (32'd0 - div_r) : div_r;
      default: md_val = (b == '0) ? a : div_r;
    endcase
  end

  // load return extension
  always_comb begin
    unique case (lk_r)
      3'd0:    ldx = {{24{it_r.load_data[7]}}, it_r.load_data[7:0]};
      3'd1:    ldx = {{16{it_r.load_data[15]}}, it_r.load_data[15:0]};
      3'd4:    ldx = {24'd0, it_r.load_data[7:0]};
      3'd5:    ldx = {16'd0, it_r.load_data[15:0]};
      default: ldx = it_r.load_data;
    endcase
  end

  // base ALU for OP and OP-IMM
  always_comb begin
    logic [31:0] opb;
    logic [4:0]  sh;
    logic        alt;
    opb = (w[6:2] == OPC_OP) ? b : immi;
    sh  = (w[6:2] == OPC_OP) ? b[4:0] : r2;
    alt = f7[5];
    unique case (f3)
      3'd0:    alt_sub: alu = ((w[6:2] == OPC_OP) && alt) ? a - opb : a + opb;
      3'd1:    alu = a << sh;
      3'd2:    alu = {31'd0, $signed(a) < $signed(opb)};
      3'd3:    alu = {31'd0, a < opb};
      3'd4:    alu = a ^ opb;
      3'd5:    alu = alt ? 32'($signed(a) >>> sh) : a >> sh;
      3'd6:    alu = a | opb;
      default: alu = a & opb;
    endcase
  end

  assign src = f3[2] ? {27'd0, r1} : a;

  always_comb begin
    r        = '0;
    r.next_pc = pc_r;
    st       = ST_OK;
    rd_want  = 1'b0;
    rd_idx   = rd;
    rd_val   = '0;
    pc_nxt   = pc_r;
    run_nxt  = run_r;
    lp_nxt   = lp_r;
    ldst_nxt = ldst_r;
    lk_nxt   = lk_r;
    csr_we   = 1'b0;
    csr_wd   = '0;
    npc      = pc_r + 32'd4;
    tgt      = '0;
    take     = 1'b0;
    unique case (it_r.action)
      ACT_START: begin
        pc_nxt    = entry_address;
        r.next_pc = entry_address;
        run_nxt   = 1'b1;
        lp_nxt    = 1'b0;
        rd_want   = 1'b1;
        rd_idx    = 5'd2;
        rd_val    = stack_top;
      end
      ACT_LDRET: begin
        if (lp_r) begin
          rd_want = 1'b1;
          rd_idx  = ldst_r;
          rd_val  = ldx;
          lp_nxt  = 1'b0;
        end
      end
      ACT_EXEC: begin
        if (!run_r) begin
          st = ST_HALTED;
        end else begin
          lp_nxt = 1'b0;
          if (w == '0) begin
            run_nxt = 1'b0;
            st      = ST_HALTED;
          end else if (w[1:0] != 2'b11) begin
            st = ST_ILLEGAL;
          end else begin
            unique case (w[6:2])
              OPC_OPIMM: begin
                if ((f3 == 3'd1 && f7 != F7_BASE) ||
                    (f3 == 3'd5 && (f7 & 7'h5F) != F7_BASE)) st = ST_ILLEGAL;
                else begin
                  rd_want = 1'b1;
                  rd_val  = alu;
                end
              end
              OPC_OP: begin
                if (f7 == F7_MULDIV) begin
                  rd_want = 1'b1;
                  rd_val  = md_val;
                end else if (f7 == F7_BASE ||
                             (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
                  rd_want = 1'b1;
                  rd_val  = alu;
                end else st = ST_ILLEGAL;
              end
              OPC_LUI: begin
                rd_want = 1'b1;
                rd_val  = {w[31:12], 12'd0};
              end
              OPC_AUIPC: begin
                rd_want = 1'b1;
                rd_val  = pc_r + {w[31:12], 12'd0};
              end
              OPC_JAL: begin
                tgt = pc_r + imm_j;
                if (tgt[1:0] != 2'd0) st = ST_MISALGN;
                else begin
                  rd_want = 1'b1;
                  rd_val  = npc;
                  npc     = tgt;
                end
              end
              OPC_JALR: begin
                tgt = (a + immi) & 32'hffff_fffe;
                if (f3 != 3'd0) st = ST_ILLEGAL;
                else if (tgt[1] != 1'b0) st = ST_MISALGN;
                else begin
                  rd_want = 1'b1;
                  rd_val  = npc;
                  npc     = tgt;
                end
              end
              OPC_BRANCH: begin
                unique case (f3)
                  3'd0:    take = (a == b);
                  3'd1:    take = (a != b);
                  3'd4:    take = $signed(a) < $signed(b);
                  3'd5:    take = !($signed(a) < $signed(b));
                  3'd6:    take = a < b;
                  3'd7:    take = a >= b;
                  default: st = ST_ILLEGAL;
                endcase
                if (take) begin
                  tgt = pc_r + imm_b;
                  if (tgt[1:0] != 2'd0) st = ST_MISALGN;
                  else npc = tgt;
                end
              end
              OPC_LOAD: begin
                if (f3 == 3'd3 || f3 > 3'd5) st = ST_ILLEGAL;
                else begin
                  r.mem_request = MEM_READ;
                  r.mem_size    = f3[1:0];
                  r.mem_address = a + immi;
                  lp_nxt        = 1'b1;
                  ldst_nxt      = rd;
                  lk_nxt        = f3;
                end
              end
              OPC_STORE: begin
                if (f3 > 3'd2) st = ST_ILLEGAL;
                else begin
                  r.mem_request    = MEM_WRITE;
                  r.mem_size       = f3[1:0];
                  r.mem_address    = a + imm_s;
                  r.mem_write_data = (f3 == 3'd0) ? {24'd0, b[7:0]} :
                                     (f3 == 3'd1) ? {16'd0, b[15:0]} : b;
                end
              end
              OPC_MISC: begin
                if (f3 != 3'd0) st = ST_ILLEGAL;
              end
              OPC_SYSTEM: begin
                if (f3 == 3'd0) begin
                  if (rd != 5'd0 || r1 != 5'd0 || (csr & 12'hFFE) != 12'd0) st = ST_ILLEGAL;
                  else if (csr == 12'd1) st = ST_BREAK;
                  else if (b[0]) begin
                    run_nxt     = 1'b0;
                    st          = ST_HALTED;
                    r.exit_code = b[31:1];
                  end else st = ST_ECALL;
                end else if (f3 == 3'd4) begin
                  st = ST_ILLEGAL;
                end else begin
                  if (f3[1:0] == 2'd1) begin
                    csr_we = 1'b1;
                    csr_wd = src;
                  end else if (r1 != 5'd0) begin
                    csr_we = 1'b1;
                    csr_wd = (f3[1:0] == 2'd2) ? (csr_old | src) : (csr_old & ~src);
                  end
                  rd_want = 1'b1;
                  rd_val  = csr_old;
                end
              end
              default: st = ST_ILLEGAL;
            endcase
          end
          if (st == ST_OK) begin
            pc_nxt    = npc;
            r.next_pc = npc;
          end
        end
      end
      default: ;
    endcase
    r.status   = st;
    r.rd_write = rd_want && (rd_idx != 5'd0);
    r.rd_index = r.rd_write ? rd_idx : 5'd0;
    r.rd_value = r.rd_write ? rd_val : 32'd0;
  end

  assign latch = ((state_r == S_READ) && !it_r.is_md) || (state_r == S_MUL) ||
                 ((state_r == S_DIV) && div_done);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_cnt_r == CSR_LAST) state_nxt = S_IDLE;
      S_IDLE: if (!q_empty) state_nxt = S_READ;
      S_READ: state_nxt = !it_r.is_md ? S_WB : it_r.is_div ? S_DIV : S_MUL;
      S_MUL:  state_nxt = S_WB;
      S_DIV:  if (div_done) state_nxt = S_WB;
      S_WB:   if (!out_full) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (latch) res_r <= r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
      rf_vld_r  <= '0;
      pc_r      <= '0;
      run_r     <= 1'b0;
      lp_r      <= 1'b0;
      ldst_r    <= '0;
      lk_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (latch) begin
        if (r.rd_write) rf_vld_r[r.rd_index] <= 1'b1;
        pc_r   <= pc_nxt;
        run_r  <= run_nxt;
        lp_r   <= lp_nxt;
        ldst_r <= ldst_nxt;
        lk_r   <= lk_nxt;
      end
    end
  end

  // x0 never becomes readable as nonzero
  a_x0_clear: assert property (@(posedge clk) disable iff (!rst_n) !rf_vld_r[0])
    else $error("x0 marked written");

  // divider completes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider done outside wait state");

  // a result is offered only after it was latched in the previous cycle or held in WB
  a_push_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |-> ($past(latch) || $past(state_r == S_WB)))
    else $error("WB entered without a latched result");

  // no request leaves the queue during the CSR clearing pass
  a_no_pop_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_pop)
    else $error("pop during clear");

endmodule

// ===== design/rv32im_zicsr_execute_core.sv =====
// RV32IM + Zicsr execute core, top level. Depends on rvx_pkg, rvx_front, rvx_back.
// The register file is read as a request is popped; it executes in S_READ, passes
// through S_MUL for MUL* or waits in S_DIV on the one-bit-per-cycle divider for
// DIV/REM, then is offered from S_WB, which stalls while the output queue is full;
// the next request is popped only after that. Reset (synchronous, rst_n low) clears
// control state, then a CSR clearing pass runs during which in_full stays high.
module rv32im_zicsr_execute_core import rvx_pkg::*; #(
  parameter int CSR_COUNT = CSR_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_instr_word,
  input  logic [31:0] in_load_data,
  // result channel
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_next_pc,
  output logic        out_rd_write,
  output logic [4:0]  out_rd_index,
  output logic [31:0] out_rd_value,
  output logic [1:0]  out_mem_request,
  output logic [1:0]  out_mem_size,
  output logic [31:0] out_mem_address,
  output logic [31:0] out_mem_write_data,
  output logic [2:0]  out_status,
  output logic [30:0] out_exit_code,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic CFG_ENTRY = 1'b0;
  localparam logic CFG_STACK = 1'b1;

  logic [31:0] entry_r, stack_r;
  item_t       q_head;
  logic        q_empty, q_pop, clearing;
  logic        rs_push, rs_full;
  res_t        rs_data;

  // output queue: two entries so a finished result can wait for pop
  res_t        oq_r [2];
  logic        owp_r, orp_r;
  logic [1:0]  ocnt_r;
  logic        opop;
  res_t        head;

  // config registers are always writable; software must write them only while idle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      stack_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENTRY: entry_r <= cfg_data;
        CFG_STACK: stack_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: accept and classify; back: execute
  rvx_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_action     (in_action),
    .in_instr_word (in_instr_word),
    .in_load_data  (in_load_data),
    .hold          (clearing),
    .q_pop         (q_pop),
    .q_empty       (q_empty),
    .q_head        (q_head)
  );

  rvx_back #(.CSR_COUNT(CSR_COUNT)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_full      (rs_full),
    .out_push      (rs_push),
    .out_res       (rs_data),
    .entry_address (entry_r),
    .stack_top     (stack_r),
    .clearing      (clearing)
  );

  assign rs_full   = (ocnt_r == 2'd2);
  assign out_empty = (ocnt_r == 2'd0);
  assign opop      = out_pop && !out_empty;
  assign head      = oq_r[orp_r];

  always_ff @(posedge clk) begin
    if (rs_push) oq_r[owp_r] <= rs_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (rs_push) owp_r <= ~owp_r;
      if (opop) orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + {1'b0, rs_push} - {1'b0, opop};
    end
  end

  assign out_next_pc        = head.next_pc;
  assign out_rd_write       = head.rd_write;
  assign out_rd_index       = head.rd_index;
  assign out_rd_value       = head.rd_value;
  assign out_mem_request    = head.mem_request;
  assign out_mem_size       = head.mem_size;
  assign out_mem_address    = head.mem_address;
  assign out_mem_write_data = head.mem_write_data;
  assign out_status         = head.status;
  assign out_exit_code      = head.exit_code;

endmodule
